// File: rtl/jqq_pkg.sv
// Shared types, constants and tables for the JPEG quality quantizer.
// Holds the base quantization tables, the quality scale table and the reciprocal table builder.
// Used by jqq_tbl_sweep and jpeg_quality_quantizer_core; depends on nothing else.
package jqq_pkg;

   localparam int COEFF_BITS_DEF = 12;
   localparam int COEFF_BITS_MAX = 16;
   localparam int VALUE_BITS     = 20;
   localparam int VALUE_MAX      = (2 ** (VALUE_BITS - 1)) - 1;
   localparam int VALUE_MIN      = -(2 ** (VALUE_BITS - 1));
   localparam int QUANT_BITS     = 8;
   localparam int QUANT_MAX      = 255;
   localparam int QUALITY_BITS   = 7;
   localparam int QUALITY_RESET  = 50;
   localparam int POS_BITS       = 6;
   localparam int ADDR_BITS      = POS_BITS + 1;
   localparam int TBL_DEPTH      = 2 ** ADDR_BITS;
   localparam int BASE_BITS      = 7;
   localparam int SCALE_BITS     = 14;
   localparam int NUM_BITS       = 21;
   localparam int RECIP_MAX_BITS = COEFF_BITS_MAX + 10;

   // Divide by 100 as multiply-and-shift; exact for dividends below 2**20.
   localparam int DIV100_SHIFT   = 27;
   localparam int DIV100_BITS    = 21;
   localparam logic [DIV100_BITS-1:0] DIV100_MUL = DIV100_BITS'(1342178);
   localparam int DIV100_PROD_BITS = (NUM_BITS - 1) + DIV100_BITS;

   localparam logic MODE_QUANTIZE   = 1'b0;
   localparam logic MODE_DEQUANTIZE = 1'b1;

   typedef logic [BASE_BITS-1:0] base_tab_type [TBL_DEPTH];
   typedef logic signed [SCALE_BITS-1:0] scale_tab_type [2 ** QUALITY_BITS];
   typedef logic [RECIP_MAX_BITS-1:0] recip_tab_type [2 ** QUANT_BITS];

   // Table write from the rebuild pipeline.
   typedef struct packed {
      logic                  valid;
      logic [ADDR_BITS-1:0]  addr;
      logic [QUANT_BITS-1:0] qz;
   } tbl_wr_type;

   // Address is {component, position}: luminance first, then chrominance.
   localparam base_tab_type BASE_TAB = '{
      16, 11, 10, 16, 24, 40, 51, 61,
      12, 12, 14, 19, 26, 58, 60, 55,
      14, 13, 16, 24, 40, 57, 69, 56,
      14, 17, 22, 29, 51, 87, 80, 62,
      18, 22, 37, 56, 68, 109, 103, 77,
      24, 35, 55, 64, 81, 104, 113, 92,
      49, 64, 78, 87, 103, 121, 120, 101,
      72, 92, 95, 98, 112, 100, 103, 99,
      17, 18, 24, 47, 99, 99, 99, 99,
      18, 21, 26, 66, 99, 99, 99, 99,
      24, 26, 56, 99, 99, 99, 99, 99,
      47, 66, 99, 99, 99, 99, 99, 99,
      99, 99, 99, 99, 99, 99, 99, 99,
      99, 99, 99, 99, 99, 99, 99, 99,
      99, 99, 99, 99, 99, 99, 99, 99,
      99, 99, 99, 99, 99, 99, 99, 99
   };

   // Quotient of two non-negative constants below 2**40, by shift and subtract.
   function automatic longint const_quot(input longint num, input longint den);
      longint rem;
      longint quo;
      rem = 0;
      quo = 0;
      for (int i = 39; i >= 0; i--) begin
         rem = (rem << 1) | ((num >> i) & longint'(1));
         quo = quo << 1;
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | longint'(1);
         end
      end
      return quo;
   endfunction

   // Scale per quality code; zero acts as one.
   function automatic scale_tab_type build_scale_tab();
      scale_tab_type t;
      for (int q = 0; q < 2 ** QUALITY_BITS; q++) begin
         if (q == 0) begin
            t[q] = SCALE_BITS'(5000);
         end else if (q < 50) begin
            t[q] = SCALE_BITS'(const_quot(longint'(5000), longint'(q)));
         end else begin
            t[q] = SCALE_BITS'(200 - 2 * q);
         end
      end
      return t;
   endfunction

   localparam scale_tab_type SCALE_TAB = build_scale_tab();

   // Reciprocal ceil(2**shift / d) per quantizer value.
   function automatic recip_tab_type build_recip_tab(input int shift);
      recip_tab_type t;
      longint        one;
      one  = longint'(1) << shift;
      t[0] = '0;
      for (int d = 1; d < 2 ** QUANT_BITS; d++) begin
         t[d] = RECIP_MAX_BITS'(const_quot(one + longint'(d) - 1, longint'(d)));
      end
      return t;
   endfunction

endpackage

// File: rtl/jqq_tbl_sweep.sv
// Rebuilds the scaled quantizer table after reset and after each quality write.
// Streams one table write per cycle over all 128 entries through a short pipeline.
// Depends on jqq_pkg.
module jqq_tbl_sweep (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cfg_we,
   input  logic [jqq_pkg::QUALITY_BITS-1:0]     cfg_quality,
   output jqq_pkg::tbl_wr_type                  tbl_wr,
   output logic                                 busy
);

   localparam int AB = jqq_pkg::ADDR_BITS;
   localparam int NB = jqq_pkg::NUM_BITS;
   localparam int PB = jqq_pkg::DIV100_PROD_BITS;
   localparam int VB = PB - jqq_pkg::DIV100_SHIFT;

   logic signed [jqq_pkg::SCALE_BITS-1:0] scale_ff, scale_in;
   logic                                  run_ff, run_in;
   logic [AB-1:0]                         cnt_ff, cnt_in;

   logic                                  a_valid_ff, a_valid_in;
   logic [AB-1:0]                         a_addr_ff, a_addr_in;
   logic signed [NB-1:0]                  a_num_ff, a_num_in;
   logic signed [jqq_pkg::SCALE_BITS+jqq_pkg::BASE_BITS:0] a_mul;

   logic                                  b_valid_ff, b_valid_in;
   logic [AB-1:0]                         b_addr_ff, b_addr_in;
   logic                                  b_low_ff, b_low_in;
   logic [PB-1:0]                         b_prod_ff, b_prod_in;

   logic [VB-1:0]                         c_val;
   jqq_pkg::tbl_wr_type                   wr_ff, wr_in;

   // sweep counter
   always_comb begin
      scale_in = scale_ff;
      run_in   = run_ff;
      cnt_in   = cnt_ff;
      if (cfg_we) begin
         scale_in = jqq_pkg::SCALE_TAB[cfg_quality];
         run_in   = 1'b1;
         cnt_in   = '0;
      end else if (run_ff) begin
         cnt_in = cnt_ff + AB'(1);
         if (cnt_ff == AB'(jqq_pkg::TBL_DEPTH - 1)) begin
            run_in = 1'b0;
         end
      end
   end

   // base * scale + 50
   always_comb begin
      a_valid_in = run_ff;
      a_addr_in  = cnt_ff;
      a_mul      = $signed({1'b0, jqq_pkg::BASE_TAB[cnt_ff]}) * scale_ff;
      a_num_in   = NB'(a_mul) + NB'(50);
   end

   // divide by 100
   always_comb begin
      b_valid_in = a_valid_ff;
      b_addr_in  = a_addr_ff;
      b_low_in   = (a_num_ff < NB'(100));
      b_prod_in  = a_num_ff[NB-2:0] * jqq_pkg::DIV100_MUL;
   end

   // clamp to 1..255
   always_comb begin
      c_val         = b_prod_ff[PB-1:jqq_pkg::DIV100_SHIFT];
      wr_in.valid   = b_valid_ff;
      wr_in.addr    = b_addr_ff;
      if (b_low_ff) begin
         wr_in.qz = jqq_pkg::QUANT_BITS'(1);
      end else if (c_val > VB'(jqq_pkg::QUANT_MAX)) begin
         wr_in.qz = jqq_pkg::QUANT_BITS'(jqq_pkg::QUANT_MAX);
      end else begin
         wr_in.qz = c_val[jqq_pkg::QUANT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff    <= jqq_pkg::SCALE_TAB[jqq_pkg::QUALITY_RESET];
         run_ff      <= 1'b1;
         cnt_ff      <= '0;
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         wr_ff       <= '0;
      end else begin
         scale_ff    <= scale_in;
         run_ff      <= run_in;
         cnt_ff      <= cnt_in;
         a_valid_ff  <= a_valid_in;
         b_valid_ff  <= b_valid_in;
         wr_ff       <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      a_addr_ff  <= a_addr_in;
      a_num_ff   <= a_num_in;
      b_addr_ff  <= b_addr_in;
      b_low_ff   <= b_low_in;
      b_prod_ff  <= b_prod_in;
   end

   assign tbl_wr = wr_ff;
   assign busy   = run_ff | a_valid_ff | b_valid_ff | wr_ff.valid;

endmodule

// File: rtl/jpeg_quality_quantizer_core.sv
// JPEG quantizer/dequantizer with quality-scaled tables: top level.
// Holds the quantizer table memory and the four-stage coefficient pipeline.
// Depends on jqq_pkg and jqq_tbl_sweep.
//
// One request enters per clock while req_stall is low and passes a four-stage
// pipeline (table read, operand prep, multiply, round/saturate); its response
// is held in the output register until taken, and the block sustains one
// coefficient per cycle when rsp_stall stays low and no rebuild is running. The
// scaled quantizer and its reciprocal live in a 128-entry memory addressed by
// {component, position}. After reset, and after every write on the csr port,
// the table is rebuilt by a sweep over all 128 entries and the drain of the
// sweep pipeline, and req_stall stays high during that time. Quantize computes
// floor division by multiplying with a stored reciprocal; dequantize multiplies
// and saturates the product to 20 bits. csr_ready is always high; write quality
// only while no request is in flight.
module jpeg_quality_quantizer_core #(
   parameter int COEFF_BITS = jqq_pkg::COEFF_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic                                 req_component,
   input  logic [jqq_pkg::POS_BITS-1:0]         req_position,
   input  logic signed [COEFF_BITS-1:0]         req_coefficient,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [jqq_pkg::VALUE_BITS-1:0] rsp_value,
   output logic [jqq_pkg::QUANT_BITS-1:0]       rsp_quantizer,
   // quality register
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [jqq_pkg::QUALITY_BITS-1:0]     csr_quality
);

   localparam int QB          = jqq_pkg::QUANT_BITS;
   localparam int VB          = jqq_pkg::VALUE_BITS;
   localparam int RECIP_SHIFT = COEFF_BITS + 9;
   localparam int RECIP_BITS  = COEFF_BITS + 10;
   localparam int DIVN_BITS   = COEFF_BITS + 1;
   localparam int DPROD_BITS  = DIVN_BITS + RECIP_BITS;
   localparam int MPROD_BITS  = COEFF_BITS + QB + 1;
   localparam int WIDE_BITS   = (MPROD_BITS > VB) ? MPROD_BITS : VB;
   localparam int MEM_BITS    = RECIP_BITS + QB;

   localparam jqq_pkg::recip_tab_type RECIP_TAB = jqq_pkg::build_recip_tab(RECIP_SHIFT);
   localparam logic signed [WIDE_BITS-1:0] SAT_MAX = WIDE_BITS'(jqq_pkg::VALUE_MAX);
   localparam logic signed [WIDE_BITS-1:0] SAT_MIN = WIDE_BITS'(jqq_pkg::VALUE_MIN);

   // Table rebuild
   jqq_pkg::tbl_wr_type tbl_wr;
   logic                tbl_busy;
   logic                cfg_we;

   assign csr_ready = 1'b1;
   assign cfg_we    = csr_valid & csr_ready;

   jqq_tbl_sweep u_sweep (
      .clock       (clock),
      .reset       (reset),
      .cfg_we      (cfg_we),
      .cfg_quality (csr_quality),
      .tbl_wr      (tbl_wr),
      .busy        (tbl_busy)
   );

   // Handshake: each stage advances when the one after it is free or moving.
   logic out_ready, s3_ready, s2_ready, s1_ready, req_accept;

   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_mode_ff;
   logic signed [COEFF_BITS-1:0] s1_coef_ff;
   logic [MEM_BITS-1:0]         s1_rd_ff;

   logic                        s2_valid_ff, s2_valid_in;
   logic                        s2_mode_ff;
   logic                        s2_neg_ff, s2_neg_in;
   logic [DIVN_BITS-1:0]        s2_num_ff, s2_num_in;
   logic [RECIP_BITS-1:0]       s2_recip_ff;
   logic [QB-1:0]               s2_qz_ff;
   logic signed [COEFF_BITS-1:0] s2_coef_ff;

   logic                        s3_valid_ff, s3_valid_in;
   logic                        s3_mode_ff;
   logic                        s3_neg_ff;
   logic [DIVN_BITS-1:0]        s3_quot_ff, s3_quot_in;
   logic signed [MPROD_BITS-1:0] s3_prod_ff, s3_prod_in;
   logic [QB-1:0]               s3_qz_ff;
   logic [DPROD_BITS-1:0]       div_prod;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [VB-1:0]        rsp_value_ff, rsp_value_in;
   logic [QB-1:0]               rsp_quantizer_ff;

   logic [MEM_BITS-1:0]         tbl_mem [jqq_pkg::TBL_DEPTH];

   logic signed [DIVN_BITS:0]   coef_ext;
   logic signed [DIVN_BITS:0]   quot_signed;
   logic signed [WIDE_BITS-1:0] prod_wide;

   assign out_ready  = ~rsp_valid_ff | ~rsp_stall;
   assign s3_ready   = ~s3_valid_ff | out_ready;
   assign s2_ready   = ~s2_valid_ff | s3_ready;
   assign s1_ready   = ~s1_valid_ff | s2_ready;
   // Hold requests off during a table rebuild, a quality write, or while stage 1 cannot advance.
   assign req_stall  = tbl_busy | csr_valid | ~s1_ready;
   assign req_accept = req_valid & ~req_stall;

   // Table memory: written by the sweep, read into the stage-1 register.
   always_ff @(posedge clock) begin
      if (tbl_wr.valid) begin
         tbl_mem[tbl_wr.addr] <= {RECIP_TAB[tbl_wr.qz][RECIP_BITS-1:0], tbl_wr.qz};
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_rd_ff   <= tbl_mem[{req_component, req_position}];
         s1_mode_ff <= req_mode;
         s1_coef_ff <= req_coefficient;
      end
   end

   // Stage 2 operands: floor of a negative quotient is -((|c| + q - 1) / q).
   always_comb begin
      s1_valid_in = s1_ready ? req_accept : s1_valid_ff;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
      coef_ext    = (DIVN_BITS + 1)'(s1_coef_ff);
      s2_neg_in   = s1_coef_ff[COEFF_BITS-1];
      if (s2_neg_in) begin
         s2_num_in = DIVN_BITS'(-coef_ext) + DIVN_BITS'(s1_rd_ff[QB-1:0]) - DIVN_BITS'(1);
      end else begin
         s2_num_in = DIVN_BITS'(coef_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_mode_ff  <= s1_mode_ff;
         s2_neg_ff   <= s2_neg_in;
         s2_num_ff   <= s2_num_in;
         s2_recip_ff <= s1_rd_ff[MEM_BITS-1:QB];
         s2_qz_ff    <= s1_rd_ff[QB-1:0];
         s2_coef_ff  <= s1_coef_ff;
      end
   end

   // Stage 3: reciprocal multiply for quantize, plain multiply for dequantize.
   always_comb begin
      s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
      div_prod    = s2_num_ff * s2_recip_ff;
      s3_quot_in  = div_prod[RECIP_SHIFT +: DIVN_BITS];
      s3_prod_in  = s2_coef_ff * $signed({1'b0, s2_qz_ff});
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_mode_ff <= s2_mode_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_quot_ff <= s3_quot_in;
         s3_prod_ff <= s3_prod_in;
         s3_qz_ff   <= s2_qz_ff;
      end
   end

   // Output: apply the sign to the quotient, saturate the product.
   always_comb begin
      rsp_valid_in = out_ready ? s3_valid_ff : rsp_valid_ff;
      quot_signed  = $signed({1'b0, s3_quot_ff});
      prod_wide    = WIDE_BITS'(s3_prod_ff);
      case (s3_mode_ff)
         jqq_pkg::MODE_QUANTIZE: begin
            if (s3_neg_ff) begin
               rsp_value_in = VB'(-quot_signed);
            end else begin
               rsp_value_in = VB'(quot_signed);
            end
         end
         jqq_pkg::MODE_DEQUANTIZE: begin
            if (prod_wide > SAT_MAX) begin
               rsp_value_in = VB'(SAT_MAX);
            end else if (prod_wide < SAT_MIN) begin
               rsp_value_in = VB'(SAT_MIN);
            end else begin
               rsp_value_in = VB'(prod_wide);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_value_ff     <= rsp_value_in;
         rsp_quantizer_ff <= s3_qz_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_quantizer = rsp_quantizer_ff;

endmodule
